/* rtl/qdc_pkg.sv */
// Shared types, constants and the quadrature lookup for the detent counter.
// No dependencies; imported by every module of the block except qdc_fifo.
package qdc_pkg;

    localparam int COUNT_W   = 16;   // width of the detent count and its limits
    localparam int TIME_W    = 32;   // microsecond timestamp width
    localparam int FAST_W    = 8;    // fast step magnitude width
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;  // widest register
    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE,
        CFG_MIN_COUNT,
        CFG_MAX_COUNT,
        CFG_PAUSE_US,
        CFG_FAST_STEP
    } t_cfg_idx;

    // detent direction codes
    localparam logic [1:0] MOVED_NONE = 2'd0;
    localparam logic [1:0] MOVED_UP   = 2'd1;
    localparam logic [1:0] MOVED_DOWN = 2'd2;

    // pin pair after reset: both channels high
    localparam logic [1:0] PINS_RESET = 2'b11;

    // {prev_a, prev_b, cur_a, cur_b} -> -1 / 0 / +1
    localparam logic signed [1:0] QUAD_TABLE [16] = '{
        2'sd0,  -2'sd1, 2'sd1,  2'sd0,
        2'sd1,  2'sd0,  2'sd0,  -2'sd1,
        -2'sd1, 2'sd0,  2'sd0,  2'sd1,
        2'sd0,  2'sd1,  -2'sd1, 2'sd0
    };

    typedef struct packed {
        logic              pin_a;
        logic              pin_b;
        logic [TIME_W-1:0] now_us;
    } t_in_beat;

    typedef struct packed {
        logic signed [COUNT_W-1:0] count;
        logic [1:0]                moved;
    } t_out_beat;

    // classified sample handed from front to back
    typedef struct packed {
        logic [1:0] moved;
        logic       fast;
    } t_cls;

    typedef struct packed {
        logic                      enable;
        logic signed [COUNT_W-1:0] min_count;
        logic signed [COUNT_W-1:0] max_count;
        logic [TIME_W-1:0]         pause_us;
        logic [FAST_W-1:0]         fast_step;
    } t_cfg;

endpackage

/* rtl/quadrature_detent_counter.sv */
// Top level of the quadrature detent counter: config registers, front, queues, back.
// Depends on qdc_pkg, qdc_fifo, qdc_front and qdc_back.
//
// Use:
//   Input channel: drive i_sample and raise i_push; the beat is taken at an
//   edge where i_push is high and o_full is low. Each beat is one sample of
//   encoder pins A/B plus a microsecond timestamp.
//   Result channel: while o_empty is low, o_result holds the oldest result
//   (count after the sample, and the detent direction); raising i_pop takes it.
//   Exactly one result beat per input beat, in order.
//   Config: i_cfg_we writes i_cfg_data into register i_cfg_idx at that edge;
//   unknown indexes are dropped. Write only while the block is drained.
// Timing:
//   The front decodes a sample in the cycle it is accepted and writes a
//   classified beat into the middle queue; once that beat heads the middle
//   queue and the output queue has room, the back turns it into a result
//   and pushes it into the output queue, where o_result shows it.
//   Throughput is one beat per cycle while the result queue has room, set by the combinational count update
//   in the back (one add and one limit compare per beat).
// Reset: both queues empty, pins taken as both high, count zero, registers
//   to enable=1, min=0, max=100, pause=20000 us, fast step=10.
// Stall: a held result fills the output queue, then the middle queue;
//   o_full rises only once both are full. Nothing is dropped.
module quadrature_detent_counter
    import qdc_pkg::*;
#(
    parameter int MID_DEPTH = MID_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_in_beat              i_sample,
    output logic                  o_full,
    input  logic                  i_pop,
    output t_out_beat             o_result,
    output logic                  o_empty,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CLS_W = $bits(t_cls);
    localparam int RES_W = $bits(t_out_beat);

    t_cfg r_cfg;

    // config registers, shared by front and back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable    <= 1'b1;
            r_cfg.min_count <= COUNT_W'(0);
            r_cfg.max_count <= COUNT_W'(100);
            r_cfg.pause_us  <= TIME_W'(20000);
            r_cfg.fast_step <= FAST_W'(10);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:    r_cfg.enable    <= i_cfg_data[0];
                CFG_MIN_COUNT: r_cfg.min_count <= i_cfg_data[COUNT_W-1:0];
                CFG_MAX_COUNT: r_cfg.max_count <= i_cfg_data[COUNT_W-1:0];
                CFG_PAUSE_US:  r_cfg.pause_us  <= i_cfg_data[TIME_W-1:0];
                CFG_FAST_STEP: r_cfg.fast_step <= i_cfg_data[FAST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic             in_fire, mid_full, mid_empty, out_full, back_fire;
    t_cls             front_cls, mid_cls;
    logic [CLS_W-1:0] mid_rdata;
    t_out_beat        back_res;
    logic [RES_W-1:0] out_rdata;

    assign in_fire   = i_push && !mid_full;
    assign o_full    = mid_full;
    assign back_fire = !mid_empty && !out_full;
    assign mid_cls   = t_cls'(mid_rdata);
    assign o_result  = t_out_beat'(out_rdata);

    qdc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (in_fire),
        .i_sample (i_sample),
        .o_cls    (front_cls)
    );

    // decouples decode from the count update
    qdc_fifo #(.WIDTH(CLS_W), .DEPTH(MID_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_fire),
        .i_data  (front_cls),
        .o_full  (mid_full),
        .i_pop   (back_fire),
        .o_empty (mid_empty),
        .o_data  (mid_rdata)
    );

    qdc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (back_fire),
        .i_cls   (mid_cls),
        .o_res   (back_res)
    );

    // result queue: a stalled receiver does not block the back end at once
    qdc_fifo #(.WIDTH(RES_W), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_fire),
        .i_data  (back_res),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (out_rdata)
    );

endmodule

/* rtl/qdc_fifo.sv */
// Small register FIFO with full/empty flags, first-word fall-through.
// Depends on nothing; DEPTH must be a power of two, at least 2.
module qdc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

/* rtl/qdc_front.sv */
// Front end: quadrature decode, step accumulation and fast-turn timing.
// Depends on qdc_pkg; emits one classified beat per accepted sample.
module qdc_front
    import qdc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    input  t_in_beat i_sample,
    output t_cls     o_cls
);

    logic [1:0]        r_prev_pins;
    logic signed [3:0] r_accum;
    logic [TIME_W-1:0] r_last_up, r_last_down;

    logic [1:0]        cur_pins;
    logic signed [1:0] delta;
    logic signed [3:0] acc_sum;
    logic [TIME_W-1:0] elapsed_up, elapsed_down;
    logic              hit_up, hit_down;

    assign cur_pins     = {i_sample.pin_a, i_sample.pin_b};
    assign delta        = QUAD_TABLE[{r_prev_pins, cur_pins}];
    assign acc_sum      = r_accum + {{2{delta[1]}}, delta};
    assign hit_up       = (acc_sum > 4'sd3);
    assign hit_down     = (acc_sum < -4'sd3);
    // wraps modulo 2^32 on its own
    assign elapsed_up   = i_sample.now_us - r_last_up;
    assign elapsed_down = i_sample.now_us - r_last_down;

    always_comb begin
        o_cls = '{moved: MOVED_NONE, fast: 1'b0};
        if (i_cfg.enable) begin
            if (hit_up) begin
                o_cls.moved = MOVED_UP;
                o_cls.fast  = (elapsed_up < i_cfg.pause_us);
            end else if (hit_down) begin
                o_cls.moved = MOVED_DOWN;
                o_cls.fast  = (elapsed_down < i_cfg.pause_us);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pins <= PINS_RESET;
            r_accum     <= '0;
            r_last_up   <= '0;
            r_last_down <= '0;
        end else if (i_valid && i_cfg.enable) begin
            r_prev_pins <= cur_pins;
            if (hit_up) begin
                r_accum   <= '0;
                r_last_up <= i_sample.now_us;
            end else if (hit_down) begin
                r_accum     <= '0;
                r_last_down <= i_sample.now_us;
            end else begin
                r_accum <= acc_sum;
            end
        end
    end

endmodule

/* rtl/qdc_back.sv */
// Back end: applies detent steps to the count with wrap at the limits.
// Depends on qdc_pkg; one result beat per classified beat.
module qdc_back
    import qdc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    input  t_cls      i_cls,
    output t_out_beat o_res
);

    // two guard bits hold count + 255 for count widths of 8 bits or more
    localparam int XW = COUNT_W + 2;

    logic signed [COUNT_W-1:0] r_count;
    logic signed [COUNT_W-1:0] n_count;
    logic signed [XW-1:0]      count_x, step_x, min_x, max_x, sum_up, sum_dn;

    assign count_x = {{2{r_count[COUNT_W-1]}}, r_count};
    assign min_x   = {{2{i_cfg.min_count[COUNT_W-1]}}, i_cfg.min_count};
    assign max_x   = {{2{i_cfg.max_count[COUNT_W-1]}}, i_cfg.max_count};
    assign step_x  = i_cls.fast ? {{(XW-FAST_W){1'b0}}, i_cfg.fast_step} : XW'(1);
    assign sum_up  = count_x + step_x;
    assign sum_dn  = count_x - step_x;

    always_comb begin
        n_count = r_count;
        case (i_cls.moved)
            MOVED_UP: begin
                n_count = (sum_up > max_x) ? i_cfg.min_count : sum_up[COUNT_W-1:0];
            end
            MOVED_DOWN: begin
                n_count = (sum_dn < min_x) ? i_cfg.max_count : sum_dn[COUNT_W-1:0];
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign o_res = '{count: n_count, moved: i_cls.moved};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_valid) begin
            r_count <= n_count;
        end
    end

endmodule

/* rtl/qdc_checker.sv */
// Port-level checks for the detent counter, bound onto the top level.
// Depends on qdc_pkg and quadrature_detent_counter.
module qdc_checker
    import qdc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_full,
    input logic                  i_pop,
    input t_out_beat             o_result,
    input logic                  o_empty,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // shadow copies of the registers the checks need
    logic                      r_en;
    logic signed [COUNT_W-1:0] r_min, r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= 1'b1;
            r_min <= COUNT_W'(0);
            r_max <= COUNT_W'(100);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:    r_en  <= i_cfg_data[0];
                CFG_MIN_COUNT: r_min <= i_cfg_data[COUNT_W-1:0];
                CFG_MAX_COUNT: r_max <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    a_reset_flags: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (o_empty && !o_full))
        else $error("queues not empty after reset");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_result)))
        else $error("waiting result beat changed");

    a_up_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.moved == MOVED_UP)
        |-> ($signed(o_result.count) <= r_max || o_result.count == r_min))
        else $error("up detent left count above max without wrap");

    a_down_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.moved == MOVED_DOWN)
        |-> ($signed(o_result.count) >= r_min || o_result.count == r_max))
        else $error("down detent left count below min without wrap");

    a_disabled_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !r_en) |-> (o_result.moved == MOVED_NONE))
        else $error("detent reported while disabled");

endmodule

bind quadrature_detent_counter qdc_checker u_qdc_checker (.*);
